FILE: src/rtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants of the RTT timeout estimator.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TIMEOUT_W = 35;
  localparam int unsigned SEC_W     = 12;
  localparam int unsigned USEC_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] USEC_PER_SEC = 32'd1000000;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_TIMEOUT = 2'd0,
    CFG_INITIAL_RTT   = 2'd1,
    CFG_INITIAL_DEV   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [SEC_W-1:0]   sample_sec;
    logic [USEC_W-1:0]  sample_usec;
  } in_item_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_usec;
    logic [DATA_W-1:0]    smoothed_out;
    logic [DATA_W-1:0]    deviation_out;
  } out_item_t;

  typedef struct packed {
    opcode_e           opcode;
    logic [DATA_W-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [DATA_W-1:0] smoothed;
    logic [DATA_W-1:0] deviation;
  } est_t;

  typedef struct packed {
    logic [DATA_W-1:0] fixed_timeout;
    logic [DATA_W-1:0] initial_rtt;
    logic [DATA_W-1:0] initial_dev;
  } cfg_t;

endpackage
`default_nettype wire

FILE: src/rtt_sample.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_sample
// Input register; joins seconds and microseconds into one microsecond count.
// ----------------------------------------------------------------------------
module rtt_sample
  import rtt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sample_t       out_data_o
);

  logic              valid_q, valid_d;
  in_item_t          item_q, item_d;
  logic [DATA_W-1:0] sec_usec;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      item_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign sec_usec = DATA_W'(item_q.sample_sec) * USEC_PER_SEC;

  assign out_valid_o       = valid_q;
  assign out_data_o.opcode = item_q.opcode;
  assign out_data_o.sample = sec_usec + DATA_W'(item_q.sample_usec);

endmodule
`default_nettype wire

FILE: src/rtt_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_update
// Holds the smoothed RTT and deviation and applies one transaction to them.
// ----------------------------------------------------------------------------
module rtt_update
  import rtt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire sample_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output est_t         out_data_o
);

  logic              valid_q, valid_d;
  sample_t           smp_q, smp_d;
  logic [DATA_W-1:0] est_q, est_d;
  logic [DATA_W-1:0] dev_q, dev_d;
  logic              fire;
  logic [DATA_W+2:0] est_sum;
  logic [DATA_W-1:0] est_new;
  logic [DATA_W-1:0] diff;
  logic [DATA_W+1:0] dev_sum;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = valid_q && out_ready_i;

  always_comb begin
    valid_d = valid_q;
    smp_d   = smp_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      smp_d   = in_data_i;
    end
  end

  // est = (7*est + s) >> 3, dev = (3*dev + |s - est|) >> 2
  always_comb begin
    est_sum = {est_q, 3'b000} - {3'b000, est_q} + {3'b000, smp_q.sample};
    est_new = est_sum[DATA_W+2:3];
    if (smp_q.sample >= est_new) begin
      diff = smp_q.sample - est_new;
    end else begin
      diff = est_new - smp_q.sample;
    end
    dev_sum = {1'b0, dev_q, 1'b0} + {2'b00, dev_q} + {2'b00, diff};
  end

  always_comb begin
    est_d = est_q;
    dev_d = dev_q;
    case (smp_q.opcode)
      OP_RESTART: begin
        est_d = cfg_i.initial_rtt;
        dev_d = cfg_i.initial_dev;
      end
      OP_SAMPLE: begin
        if (cfg_i.fixed_timeout == '0) begin
          est_d = est_new;
          dev_d = dev_sum[DATA_W+1:2];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      est_q   <= '0;
      dev_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (fire) begin
        est_q <= est_d;
        dev_q <= dev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign out_valid_o          = valid_q;
  assign out_data_o.smoothed  = est_d;
  assign out_data_o.deviation = dev_d;

endmodule
`default_nettype wire

FILE: src/rtt_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_out
// Registers the new state, forms the timeout and drives the result register.
// ----------------------------------------------------------------------------
module rtt_out
  import rtt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire est_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  logic      mid_valid_q, mid_valid_d;
  est_t      mid_q, mid_d;
  logic      res_valid_q, res_valid_d;
  out_item_t res_q, res_d;
  logic      res_ready;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign in_ready_o = !mid_valid_q || res_ready;

  always_comb begin
    mid_valid_d = mid_valid_q;
    mid_d       = mid_q;
    if (in_ready_o) begin
      mid_valid_d = in_valid_i;
      mid_d       = in_data_i;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_ready) begin
      res_valid_d         = mid_valid_q;
      res_d.smoothed_out  = mid_q.smoothed;
      res_d.deviation_out = mid_q.deviation;
      if (cfg_i.fixed_timeout != '0) begin
        res_d.timeout_usec = TIMEOUT_W'(cfg_i.fixed_timeout);
      end else begin
        res_d.timeout_usec = TIMEOUT_W'(mid_q.smoothed)
                           + {1'b0, mid_q.deviation, 2'b00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

FILE: src/rtt_timeout_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_timeout_estimator
// Retransmission timeout estimator with smoothed RTT and mean deviation.
// ----------------------------------------------------------------------------
// Four register stages (input, sample, new state, result); a transaction
// passes them in that order, and one transaction is taken every cycle
// while the result side does not stall. The state update (estimate,
// deviation) is the single feedback path and closes within the update
// stage. Configuration is written without wait states and must
// only change while no transaction is in flight.
module rtt_timeout_estimator
  import rtt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    smp_ready;
  logic    smp_valid;
  sample_t smp_data;
  logic    upd_valid;
  logic    upd_ready;
  est_t    upd_data;
  logic    out_in_ready;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIXED_TIMEOUT: cfg_d.fixed_timeout = cfg_data_i;
        CFG_INITIAL_RTT:   cfg_d.initial_rtt   = cfg_data_i;
        CFG_INITIAL_DEV:   cfg_d.initial_dev   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !smp_ready;

  rtt_sample u_sample (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (smp_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (smp_valid),
    .out_ready_i (upd_ready),
    .out_data_o  (smp_data)
  );

  rtt_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (smp_valid),
    .in_ready_o  (upd_ready),
    .in_data_i   (smp_data),
    .out_valid_o (upd_valid),
    .out_ready_i (out_in_ready),
    .out_data_o  (upd_data)
  );

  rtt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (upd_valid),
    .in_ready_o  (out_in_ready),
    .in_data_i   (upd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // backpressure only ever originates at the result side
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_in_ready |-> out_valid_o && out_stall_i)
    else $error("result stage blocked without output stall");

  a_input_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> smp_valid && !upd_ready && upd_valid && !out_in_ready)
    else $error("input stalled while pipeline has room");

  a_handoff_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_valid && out_in_ready && !out_stall_i |=> ##1 out_valid_o)
    else $error("updated state did not reach the result register");

endmodule
`default_nettype wire

FILE: bench/rtt_timeout_estimator_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_timeout_estimator_checker
// Watches the sample, result and register channels of the RTT timeout
// estimator. It keeps its own smoothed RTT, deviation and register copies,
// predicts the result of every accepted transaction and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rtt_timeout_estimator_checker
  import rtt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire in_item_t             in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire out_item_t            out_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t              shadow_cfg = '0;
  logic [DATA_W-1:0] est_rtt    = '0;
  logic [DATA_W-1:0] est_dev    = '0;
  out_item_t         expected_timeouts_q[$];
  int unsigned       n_fail     = 0;
  int unsigned       n_checked  = 0;

  assign fail_count_o = n_fail;
  assign checked_o    = n_checked;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    n_fail++;
  endtask

  function automatic out_item_t advance_estimator(input in_item_t it);
    out_item_t   res;
    logic [63:0] rtt_sample;
    logic [63:0] new_est;
    logic [63:0] abs_err;
    logic [63:0] new_dev;
    rtt_sample = {52'd0, it.sample_sec} * {32'd0, USEC_PER_SEC} + {44'd0, it.sample_usec};
    if (it.opcode == OP_RESTART) begin
      est_rtt = shadow_cfg.initial_rtt;
      est_dev = shadow_cfg.initial_dev;
    end else if (it.opcode == OP_SAMPLE && shadow_cfg.fixed_timeout == '0) begin
      new_est = ({32'd0, est_rtt} * 64'd7 + rtt_sample) >> 3;
      abs_err = (rtt_sample >= new_est) ? rtt_sample - new_est : new_est - rtt_sample;
      new_dev = ({32'd0, est_dev} * 64'd3 + abs_err) >> 2;
      est_rtt = new_est[DATA_W-1:0];
      est_dev = new_dev[DATA_W-1:0];
    end
    if (shadow_cfg.fixed_timeout != '0) begin
      res.timeout_usec = {3'd0, shadow_cfg.fixed_timeout};
    end else begin
      res.timeout_usec = {3'd0, est_rtt} + {1'b0, est_dev, 2'b00};
    end
    res.smoothed_out  = est_rtt;
    res.deviation_out = est_dev;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      shadow_cfg = '0;
      est_rtt    = '0;
      est_dev    = '0;
      expected_timeouts_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIXED_TIMEOUT: shadow_cfg.fixed_timeout = cfg_data_i;
          CFG_INITIAL_RTT:   shadow_cfg.initial_rtt   = cfg_data_i;
          CFG_INITIAL_DEV:   shadow_cfg.initial_dev   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_timeouts_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", n_checked));
        end else begin
          exp_res = expected_timeouts_q.pop_front();
          if (out_data_i.timeout_usec !== exp_res.timeout_usec)
            report($sformatf("result %0d timeout_usec: expected %0d, got %0d", n_checked,
                             exp_res.timeout_usec, out_data_i.timeout_usec));
          if (out_data_i.smoothed_out !== exp_res.smoothed_out)
            report($sformatf("result %0d smoothed_out: expected %0d, got %0d", n_checked,
                             exp_res.smoothed_out, out_data_i.smoothed_out));
          if (out_data_i.deviation_out !== exp_res.deviation_out)
            report($sformatf("result %0d deviation_out: expected %0d, got %0d", n_checked,
                             exp_res.deviation_out, out_data_i.deviation_out));
        end
        n_checked++;
      end
      if (in_valid_i && !in_stall_i)
        expected_timeouts_q.push_back(advance_estimator(in_data_i));
      pending_o <= expected_timeouts_q.size();
    end
  end

endmodule
`default_nettype wire

FILE: bench/rtt_timeout_estimator_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_timeout_estimator_tb
// Stimulus and verdict for the RTT timeout estimator. A directed part hits
// the field extremes, every opcode, frozen and fixed-timeout behavior; then
// random phases under varied register settings, with bursty input, patterned
// output stalls and long output hold-offs that back the pipeline up.
// ----------------------------------------------------------------------------
module rtt_timeout_estimator_tb
  import rtt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        OP_UNUSED   = 2'd3;
  localparam logic [DATA_W-1:0] WORD_MAX    = '1;
  localparam int unsigned       SETTLE      = 8;
  localparam int unsigned       LONG_HOLD   = 300;
  localparam int unsigned       N_PHASES    = 12;
  localparam int unsigned       PHASE_ITEMS = 100;
  localparam int unsigned       LIMIT_NS    = 2_000_000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_item_t             in_data_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;
  wire logic            in_stall_o;
  wire logic            out_valid_o;
  wire out_item_t       out_data_o;
  wire logic            cfg_ready_o;

  int unsigned       fails;
  int unsigned       pending;
  int unsigned       checked;
  int unsigned       hold_req   = 0;
  int unsigned       burst_left = 0;
  logic [DATA_W-1:0] cur_fixed  = '0;
  int unsigned       n_sample = 0, n_query = 0, n_restart = 0, n_unused = 0;
  int unsigned       n_frozen = 0, n_settings = 0;

  rtt_timeout_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rtt_timeout_estimator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [SEC_W-1:0] sec,
                                  input logic [USEC_W-1:0] usec);
    in_item_t it;
    it.opcode      = opcode_e'(op);
    it.sample_sec  = sec;
    it.sample_usec = usec;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned pick;
    logic [1:0]  op;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    pick = $urandom_range(0, 99);
    if (pick < 62)      op = OP_SAMPLE;
    else if (pick < 80) op = OP_QUERY;
    else if (pick < 92) op = OP_RESTART;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      sec  = SEC_W'($urandom_range(0, 3));
      usec = USEC_W'($urandom_range(0, 999999));
    end else if (pick < 75) begin
      sec  = SEC_W'($urandom_range(0, 4095));
      usec = USEC_W'($urandom_range(0, 1048575));
    end else if (pick < 85) begin
      sec  = '1;
      usec = '1;
    end else if (pick < 92) begin
      sec  = '0;
      usec = '0;
    end else begin
      sec  = '0;
      usec = USEC_W'($urandom_range(0, 50));
    end
    return mk(op, sec, usec);
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return $urandom;
      default: return $urandom_range(0, 3000000);
    endcase
  endfunction

  task automatic offer(input in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (it.opcode)
      OP_SAMPLE:  n_sample++;
      OP_QUERY:   n_query++;
      OP_RESTART: n_restart++;
      default:    n_unused++;
    endcase
    if (cur_fixed != '0) n_frozen++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 80) : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [DATA_W-1:0] fixed, input logic [DATA_W-1:0] rtt0,
                           input logic [DATA_W-1:0] dev0);
    put_reg(CFG_FIXED_TIMEOUT, fixed);
    put_reg(CFG_INITIAL_RTT, rtt0);
    put_reg(CFG_INITIAL_DEV, dev0);
    cfg_valid_i <= 1'b0;
    cur_fixed = fixed;
    n_settings++;
    @(posedge clk_i);
  endtask

  // output side: stall patterns that change every so often, plus long hold-offs
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_seen;
    mode      = 0;
    mode_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        mode_left = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 7) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout: %0d results still expected", pending);
    $display("** rtt_timeout_estimator: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: adaptive, everything zero
    offer(mk(OP_QUERY, '0, '0));
    offer(mk(OP_SAMPLE, '1, '1));
    offer(mk(OP_UNUSED, '1, '0));
    offer(mk(OP_SAMPLE, '0, '0));
    offer(mk(OP_SAMPLE, '0, 20'd999999));
    offer(mk(OP_RESTART, '0, '0));
    quiesce();

    load_regs('0, WORD_MAX, WORD_MAX);
    offer(mk(OP_RESTART, '0, '0));
    offer(mk(OP_QUERY, '0, '0));
    offer(mk(OP_SAMPLE, '0, '0));
    offer(mk(OP_SAMPLE, '1, '1));
    offer(mk(OP_RESTART, '1, '1));
    quiesce();

    // fixed timeout: samples freeze the state, restart still reloads
    load_regs(WORD_MAX, 32'd1, 32'd2);
    offer(mk(OP_SAMPLE, 12'd1, '0));
    offer(mk(OP_RESTART, '0, '0));
    offer(mk(OP_UNUSED, '0, '1));
    offer(mk(OP_QUERY, '1, '1));
    offer(mk(OP_SAMPLE, '1, '1));
    quiesce();

    load_regs(32'd1, '0, WORD_MAX);
    offer(mk(OP_SAMPLE, 12'd2, 20'd500000));
    offer(mk(OP_RESTART, '0, '0));
    quiesce();

    load_regs('0, 32'd1000000, '0);
    offer(mk(OP_RESTART, '0, '0));
    offer(mk(OP_SAMPLE, '0, 20'd100));
    offer(mk(OP_SAMPLE, 12'd2, '0));
    quiesce();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      logic [DATA_W-1:0] fixed;
      case ($urandom_range(0, 9))
        0:       fixed = WORD_MAX;
        1:       fixed = 32'd1;
        2:       fixed = $urandom;
        default: fixed = '0;
      endcase
      load_regs(fixed, rand_word(), rand_word());
      if (ph == 3 || ph == 8) hold_req <= hold_req + 1;
      if ($urandom_range(0, 9) < 7) offer(mk(OP_RESTART, '0, '0));
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) offer(rand_item());
      quiesce();
    end

    $display("Covered %0d transactions: %0d samples, %0d queries, %0d restarts, %0d unused op",
             n_sample + n_query + n_restart + n_unused, n_sample, n_query, n_restart, n_unused);
    $display("%0d settings, %0d under fixed timeout, %0d long hold-offs, %0d results checked",
             n_settings, n_frozen, hold_req, checked);
    if (fails == 0) begin
      $display("** rtt_timeout_estimator: PASSED **");
    end else begin
      $display("** rtt_timeout_estimator: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
src/rtt_pkg.sv
src/rtt_sample.sv
src/rtt_update.sv
src/rtt_out.sv
src/rtt_timeout_estimator.sv
bench/rtt_timeout_estimator_checker.sv
bench/rtt_timeout_estimator_tb.sv
